/* sv/assert_macros.svh */
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check, disabled while reset is held
`define ASSERT_IMPL(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Antecedent in one cycle, consequent in the next
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* sv/spmf_pkg.sv */
// Types, codes and sizing helpers for the strict priority multi-FIFO
package spmf_pkg;

    localparam int LEVEL_COUNT       = 8;
    localparam int LVL_W             = 3;
    localparam int STAT_W            = 32;
    localparam int DEPTH_HIGH_DEF    = 32;
    localparam int DEPTH_DEFAULT_DEF = 16;
    localparam int DEPTH_LOW_DEF     = 8;
    localparam int DATA_WIDTH_DEF    = 64;

    typedef enum logic [2:0] {
        CMD_PUSH        = 3'd0,
        CMD_POP         = 3'd1,
        CMD_FLUSH       = 3'd2,
        CMD_FLUSH_ALL   = 3'd3,
        CMD_READ_STATS  = 3'd4,
        CMD_RESET_STATS = 3'd5
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_QUEUE,
        UPD_DROP,
        UPD_DEQUEUE,
        UPD_CLEAR
    } t_upd;

    typedef enum logic {
        S_IDLE,
        S_WB
    } t_state;

    typedef struct packed {
        t_status            status;
        logic [LVL_W-1:0]   level;
    } t_qresp;

    typedef struct packed {
        logic [3:0] next_level;
        logic [7:0] total;
    } t_occ;

    function automatic int spmf_cap(int lv, int dh, int dd, int dl);
        if (lv < 3) return dh;
        if (lv < 5) return dd;
        return dl;
    endfunction

    // first store slot of a level; level LEVEL_COUNT gives the whole store size
    function automatic int spmf_base(int lv, int dh, int dd, int dl);
        int b;
        b = 0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            if (i < lv) b += spmf_cap(i, dh, dd, dl);
        end
        return b;
    endfunction

    function automatic int spmf_max3(int a, int b, int c);
        int m;
        m = a;
        if (b > m) m = b;
        if (c > m) m = c;
        return m;
    endfunction

endpackage

/* sv/spmf_store.sv */
// Message store: one synchronous RAM shared by all levels
module spmf_store import spmf_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int ENTRIES    = 152
) (
    input  logic                              i_clk,
    input  logic                              i_we,
    input  logic                              i_re,
    input  logic [$clog2(ENTRIES)-1:0]        i_addr,
    input  logic [DATA_WIDTH-1:0]             i_wdata,
    output logic [DATA_WIDTH-1:0]             o_rdata
);

    localparam int AW = $clog2(ENTRIES);

    logic [DATA_WIDTH-1:0] r_mem [ENTRIES];
    logic [DATA_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_addr[AW-1:0]] <= i_wdata;
        if (i_re) r_rdata <= r_mem[i_addr[AW-1:0]];
    end

    assign o_rdata = r_rdata;

endmodule

/* sv/spmf_queue.sv */
// Per-level head, tail and fill registers with the priority encoder
module spmf_queue import spmf_pkg::*; #(
    parameter int DEPTH_HIGH    = DEPTH_HIGH_DEF,
    parameter int DEPTH_DEFAULT = DEPTH_DEFAULT_DEF,
    parameter int DEPTH_LOW     = DEPTH_LOW_DEF,
    parameter int FILL_W        = 6,
    parameter int AW            = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_acc,
    input  logic [2:0]          i_cmd,
    input  logic [LVL_W-1:0]    i_level,
    input  logic [LVL_W-1:0]    i_sel_level,
    output logic                o_we,
    output logic                o_re,
    output logic [AW-1:0]       o_addr,
    output t_qresp              o_resp,
    output logic [FILL_W-1:0]   o_sel_fill,
    output t_occ                o_occ
);

    localparam int IDX_W = FILL_W - 1;
    localparam int SUM_W = FILL_W + LVL_W;

    logic [FILL_W-1:0] w_cap  [LEVEL_COUNT];
    logic [AW-1:0]     w_base [LEVEL_COUNT];
    logic [IDX_W-1:0]  r_head [LEVEL_COUNT];
    logic [IDX_W-1:0]  r_tail [LEVEL_COUNT];
    logic [FILL_W-1:0] r_fill [LEVEL_COUNT];

    logic              w_any;
    logic [LVL_W-1:0]  w_pop_lv;
    logic              w_full;
    logic [IDX_W-1:0]  w_tail_nx;
    logic [IDX_W-1:0]  w_head_nx;
    logic [SUM_W-1:0]  w_sum;
    logic              w_push;
    logic              w_pop;

    for (genvar g = 0; g < LEVEL_COUNT; g++) begin : g_lvl
        assign w_cap[g]  = FILL_W'(spmf_cap(g, DEPTH_HIGH, DEPTH_DEFAULT, DEPTH_LOW));
        assign w_base[g] = AW'(spmf_base(g, DEPTH_HIGH, DEPTH_DEFAULT, DEPTH_LOW));
    end

    always_comb begin
        w_any    = 1'b0;
        w_pop_lv = '0;
        for (int i = LEVEL_COUNT - 1; i >= 0; i--) begin
            if (r_fill[i] != '0) begin
                w_any    = 1'b1;
                w_pop_lv = LVL_W'(i);
            end
        end
        w_sum = '0;
        for (int i = 0; i < LEVEL_COUNT; i++) begin
            w_sum = w_sum + SUM_W'(r_fill[i]);
        end
    end

    always_comb begin
        w_full    = r_fill[i_level] >= w_cap[i_level];
        w_tail_nx = (({1'b0, r_tail[i_level]} + 1'b1) == w_cap[i_level]) ? '0 :
                    r_tail[i_level] + 1'b1;
        w_head_nx = (({1'b0, r_head[w_pop_lv]} + 1'b1) == w_cap[w_pop_lv]) ? '0 :
                    r_head[w_pop_lv] + 1'b1;
        w_push    = i_acc && (i_cmd == CMD_PUSH) && !w_full;
        w_pop     = i_acc && (i_cmd == CMD_POP) && w_any;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_fill[i] <= '0;
            end
        end else if (i_acc) begin
            unique case (i_cmd)
                CMD_PUSH: begin
                    if (!w_full) begin
                        r_tail[i_level] <= w_tail_nx;
                        r_fill[i_level] <= r_fill[i_level] + 1'b1;
                    end
                end
                CMD_POP: begin
                    if (w_any) begin
                        r_head[w_pop_lv] <= w_head_nx;
                        r_fill[w_pop_lv] <= r_fill[w_pop_lv] - 1'b1;
                    end
                end
                CMD_FLUSH: begin
                    r_head[i_level] <= '0;
                    r_tail[i_level] <= '0;
                    r_fill[i_level] <= '0;
                end
                CMD_FLUSH_ALL: begin
                    for (int i = 0; i < LEVEL_COUNT; i++) begin
                        r_head[i] <= '0;
                        r_tail[i] <= '0;
                        r_fill[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        o_we   = w_push;
        o_re   = w_pop;
        o_addr = (i_cmd == CMD_POP) ? w_base[w_pop_lv] + AW'(r_head[w_pop_lv]) :
                 w_base[i_level] + AW'(r_tail[i_level]);
        if ((i_cmd == CMD_PUSH) && w_full) begin
            o_resp.status = ST_FULL;
        end else if ((i_cmd == CMD_POP) && !w_any) begin
            o_resp.status = ST_EMPTY;
        end else begin
            o_resp.status = ST_OK;
        end
        o_resp.level    = ((i_cmd == CMD_POP) && w_any) ? w_pop_lv : i_level;
        o_sel_fill      = r_fill[i_sel_level];
        // read in write-back, so these reflect the fills after the step
        o_occ.next_level = w_any ? {1'b0, w_pop_lv} : 4'(LEVEL_COUNT);
        o_occ.total      = 8'(w_sum);
    end

endmodule

/* sv/spmf_stats.sv */
// Per-level statistics RAM with read-modify-write and valid bits
module spmf_stats import spmf_pkg::*; #(
    parameter int FILL_W = 6
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_rd_en,
    input  logic [LVL_W-1:0]    i_rd_level,
    input  t_upd                i_upd,
    input  logic                i_commit,
    input  logic [FILL_W-1:0]   i_fill,
    output logic [STAT_W-1:0]   o_queued,
    output logic [STAT_W-1:0]   o_dequeued,
    output logic [STAT_W-1:0]   o_overflow,
    output logic [FILL_W-1:0]   o_peak
);

    localparam int ENT_W = 3 * STAT_W + FILL_W;

    logic [ENT_W-1:0]       r_mem [LEVEL_COUNT];
    logic [LEVEL_COUNT-1:0] r_vld;
    logic [ENT_W-1:0]       r_rd_data;
    logic                   r_rd_vld;
    logic [LVL_W-1:0]       r_rd_lv;

    logic [ENT_W-1:0]       w_old;
    logic [STAT_W-1:0]      w_q, w_d, w_o;
    logic [FILL_W-1:0]      w_p, w_pmax;
    logic                   w_wr;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_level];
            r_rd_lv   <= i_rd_level;
        end
        if (w_wr) r_mem[r_rd_lv] <= {w_p, w_o, w_d, w_q};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) r_rd_vld <= r_vld[i_rd_level];
            if (i_commit && (i_upd == UPD_CLEAR)) begin
                r_vld <= '0;
            end else if (w_wr) begin
                r_vld[r_rd_lv] <= 1'b1;
            end
        end
    end

    always_comb begin
        w_old = r_rd_vld ? r_rd_data : '0;
        w_q   = w_old[STAT_W-1:0];
        w_d   = w_old[2*STAT_W-1:STAT_W];
        w_o   = w_old[3*STAT_W-1:2*STAT_W];
        w_p   = w_old[ENT_W-1:3*STAT_W];
        w_pmax = (i_fill > w_p) ? i_fill : w_p;
        unique case (i_upd)
            UPD_QUEUE: begin
                w_q = w_q + 1'b1;
                w_p = w_pmax;
            end
            UPD_DROP: begin
                w_o = w_o + 1'b1;
                w_p = w_pmax;
            end
            UPD_DEQUEUE: begin
                w_d = w_d + 1'b1;
                w_p = w_pmax;
            end
            UPD_CLEAR: begin
                w_q = '0;
                w_d = '0;
                w_o = '0;
                w_p = '0;
            end
            UPD_NONE: ;
            default: ;
        endcase
        w_wr = i_commit &&
               ((i_upd == UPD_QUEUE) || (i_upd == UPD_DROP) || (i_upd == UPD_DEQUEUE));
        o_queued   = w_q;
        o_dequeued = w_d;
        o_overflow = w_o;
        o_peak     = w_p;
    end

endmodule

/* sv/strict_priority_multi_fifo_unit.sv */
// Top level of the strict priority multi-FIFO: sequencer, output register, checks
//
// Eight message FIFOs, one per priority level, behind one command stream.
// Slave channel: tuser carries command and level, tdata the message word.
// Commands: push, pop (lowest-numbered non-empty level), flush one level,
// flush all, read stats, reset stats. Every item gives exactly one result.
// Master channel: tuser carries the status, tdata the popped word, popped
// level, next non-empty level, total and per-level fill and the addressed
// level's statistics.
// Timing: an item is taken at an edge, its statistics entry is read from RAM
// in that cycle and written back in the write-back state, where the result is
// loaded into the output register once that register is free. The block takes
// no new item until the last one is written back, set by the read-modify-write
// of the statistics RAM.
// Reset empties all levels and clears all statistics at once through valid
// bits; no clearing pass is needed. When the receiver stalls, the result is
// held and one further item may be taken; its write-back waits until the
// output register is free.
`include "assert_macros.svh"

module strict_priority_multi_fifo_unit import spmf_pkg::*; #(
    parameter int DEPTH_HIGH    = DEPTH_HIGH_DEF,
    parameter int DEPTH_DEFAULT = DEPTH_DEFAULT_DEF,
    parameter int DEPTH_LOW     = DEPTH_LOW_DEF,
    parameter int DATA_WIDTH    = DATA_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [63:0]  i_s_axis_tdata,   // message_data
    input  logic [5:0]   i_s_axis_tuser,   // command, level
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // popped_data, popped_level, next_level, total_waiting, level_waiting,
    // queued_total, dequeued_total, overflow_total, peak_depth, zero pad
    output logic [191:0] o_m_axis_tdata,
    output logic [1:0]   o_m_axis_tuser    // status
);

    localparam int MAX_D   = spmf_max3(DEPTH_HIGH, DEPTH_DEFAULT, DEPTH_LOW);
    localparam int IDX_W   = (MAX_D > 1) ? $clog2(MAX_D) : 1;
    localparam int FILL_W  = IDX_W + 1;
    localparam int ENTRIES = spmf_base(LEVEL_COUNT, DEPTH_HIGH, DEPTH_DEFAULT, DEPTH_LOW);
    localparam int AW      = $clog2(ENTRIES);

    t_state              r_state, n_state;
    logic                w_in_acc;
    logic                w_commit;
    logic [2:0]          r_cmd;
    t_status             r_status;
    logic [LVL_W-1:0]    r_lv;
    t_upd                r_upd, w_upd;

    logic                w_we, w_re;
    logic [AW-1:0]       w_addr;
    t_qresp              w_resp;
    logic [FILL_W-1:0]   w_sel_fill;
    t_occ                w_occ;
    logic [DATA_WIDTH-1:0] w_rdata;
    logic [STAT_W-1:0]   w_queued, w_dequeued, w_overflow;
    logic [FILL_W-1:0]   w_peak;

    logic                w_popped;
    logic [191:0]        w_tdata;
    logic                r_out_vld;
    logic [191:0]        r_out_tdata;
    t_status             r_out_status;

    spmf_queue #(
        .DEPTH_HIGH    (DEPTH_HIGH),
        .DEPTH_DEFAULT (DEPTH_DEFAULT),
        .DEPTH_LOW     (DEPTH_LOW),
        .FILL_W        (FILL_W),
        .AW            (AW)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_acc       (w_in_acc),
        .i_cmd       (i_s_axis_tuser[2:0]),
        .i_level     (i_s_axis_tuser[5:3]),
        .i_sel_level (r_lv),
        .o_we        (w_we),
        .o_re        (w_re),
        .o_addr      (w_addr),
        .o_resp      (w_resp),
        .o_sel_fill  (w_sel_fill),
        .o_occ       (w_occ)
    );

    spmf_store #(
        .DATA_WIDTH (DATA_WIDTH),
        .ENTRIES    (ENTRIES)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_re    (w_re),
        .i_addr  (w_addr),
        .i_wdata (i_s_axis_tdata[DATA_WIDTH-1:0]),
        .o_rdata (w_rdata)
    );

    spmf_stats #(
        .FILL_W (FILL_W)
    ) u_stats (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_en    (w_in_acc),
        .i_rd_level (w_resp.level),
        .i_upd      (r_upd),
        .i_commit   (w_commit),
        .i_fill     (w_sel_fill),
        .o_queued   (w_queued),
        .o_dequeued (w_dequeued),
        .o_overflow (w_overflow),
        .o_peak     (w_peak)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = S_WB;
            S_WB:   if (w_commit) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == S_IDLE) && i_rst_n;
        w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
        w_commit        = (r_state == S_WB) && (!r_out_vld || i_m_axis_tready);
    end

    always_comb begin
        unique case (i_s_axis_tuser[2:0])
            CMD_PUSH:        w_upd = (w_resp.status == ST_FULL) ? UPD_DROP : UPD_QUEUE;
            CMD_POP:         w_upd = (w_resp.status == ST_EMPTY) ? UPD_NONE : UPD_DEQUEUE;
            CMD_RESET_STATS: w_upd = UPD_CLEAR;
            default:         w_upd = UPD_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= i_s_axis_tuser[2:0];
            r_status <= w_resp.status;
            r_lv     <= w_resp.level;
            r_upd    <= w_upd;
        end
    end

    always_comb begin
        w_popped = (r_cmd == CMD_POP) && (r_status == ST_OK);
        w_tdata  = {5'd0,
                    6'(w_peak),
                    w_overflow,
                    w_dequeued,
                    w_queued,
                    6'(w_sel_fill),
                    w_occ.total,
                    w_occ.next_level,
                    w_popped ? r_lv : 3'd0,
                    w_popped ? 64'(w_rdata) : 64'd0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_commit) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_tdata  <= w_tdata;
            r_out_status <= r_status;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = r_out_tdata;
    assign o_m_axis_tuser  = r_out_status;

    `ASSERT_NEXT(a_acc_to_wb, i_clk, i_rst_n, w_in_acc, r_state == S_WB,
        "item not in write-back")
    `ASSERT_IMPL(a_empty_occ, i_clk, i_rst_n,
        (o_m_axis_tvalid && (o_m_axis_tuser == ST_EMPTY)) |->
        ((o_m_axis_tdata[70:67] == 4'(LEVEL_COUNT)) && (o_m_axis_tdata[78:71] == 8'd0)),
        "empty pop with items waiting")
    `ASSERT_IMPL(a_out_from_wb, i_clk, i_rst_n,
        $rose(o_m_axis_tvalid) |-> $past(r_state == S_WB), "result without write-back")

endmodule

/* tb/sv/strict_priority_multi_fifo_unit_tb.sv */
// Self-checking testbench for the strict priority multi-FIFO unit, with a scoreboard class
module strict_priority_multi_fifo_unit_tb;
    import spmf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // command codes with no operation behind them; the block treats them as read stats
    localparam logic [2:0] CMD_SPARE_A = 3'd6;
    localparam logic [2:0] CMD_SPARE_B = 3'd7;
    localparam int         LONG_HOLD   = 300;
    localparam int         ITEM_TARGET = 900;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] popped_data;
        logic [2:0]  popped_level;
        logic [3:0]  next_level;
        logic [7:0]  total_waiting;
        logic [5:0]  level_waiting;
        logic [31:0] queued_total;
        logic [31:0] dequeued_total;
        logic [31:0] overflow_total;
        logic [5:0]  peak_depth;
    } t_outcome;

    class spmf_scoreboard;
        logic [63:0] level_q [LEVEL_COUNT][$];
        logic [31:0] queued_cnt [LEVEL_COUNT];
        logic [31:0] dequeued_cnt [LEVEL_COUNT];
        logic [31:0] overflow_cnt [LEVEL_COUNT];
        logic [5:0]  peak [LEVEL_COUNT];
        t_outcome    outcome_q [$];
        int          accepted;
        int          fails;

        function new();
            for (int i = 0; i < LEVEL_COUNT; i++) begin
                queued_cnt[i]   = '0;
                dequeued_cnt[i] = '0;
                overflow_cnt[i] = '0;
                peak[i]         = '0;
            end
            accepted = 0;
            fails    = 0;
        endfunction

        function int depth_of(int lv);
            if (lv < 3) return 32;
            if (lv < 5) return 16;
            return 8;
        endfunction

        function int pending();
            return outcome_q.size();
        endfunction

        // predicts the result of one accepted item and queues it
        function void note_input(logic [2:0] cmd, logic [2:0] lv, logic [63:0] data);
            t_outcome o;
            int       addr;
            int       total;
            int       i;
            o      = '0;
            o.status = ST_OK;
            addr   = lv;
            case (cmd)
                CMD_PUSH: begin
                    if (level_q[lv].size() >= depth_of(lv)) begin
                        overflow_cnt[lv]++;
                        o.status = ST_FULL;
                    end else begin
                        level_q[lv].push_back(data);
                        queued_cnt[lv]++;
                    end
                    if (level_q[lv].size() > peak[lv]) peak[lv] = 6'(level_q[lv].size());
                end
                CMD_POP: begin
                    o.status = ST_EMPTY;
                    for (i = 0; i < LEVEL_COUNT; i++) begin
                        if (o.status == ST_EMPTY && level_q[i].size() > 0) begin
                            o.popped_data  = level_q[i].pop_front();
                            o.popped_level = 3'(i);
                            o.status       = ST_OK;
                            dequeued_cnt[i]++;
                            // peak may lag the fill after a stats reset
                            if (level_q[i].size() > peak[i]) peak[i] = 6'(level_q[i].size());
                            addr = i;
                        end
                    end
                end
                CMD_FLUSH: level_q[lv].delete();
                CMD_FLUSH_ALL: begin
                    for (i = 0; i < LEVEL_COUNT; i++) level_q[i].delete();
                end
                CMD_RESET_STATS: begin
                    for (i = 0; i < LEVEL_COUNT; i++) begin
                        queued_cnt[i]   = '0;
                        dequeued_cnt[i] = '0;
                        overflow_cnt[i] = '0;
                        peak[i]         = '0;
                    end
                end
                default: ;
            endcase
            o.next_level = 4'(LEVEL_COUNT);
            total = 0;
            for (i = LEVEL_COUNT - 1; i >= 0; i--) begin
                if (level_q[i].size() > 0) o.next_level = 4'(i);
                total += level_q[i].size();
            end
            o.total_waiting  = 8'(total);
            o.level_waiting  = 6'(level_q[addr].size());
            o.queued_total   = queued_cnt[addr];
            o.dequeued_total = dequeued_cnt[addr];
            o.overflow_total = overflow_cnt[addr];
            o.peak_depth     = peak[addr];
            outcome_q.push_back(o);
            accepted++;
        endfunction

        function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                fails++;
            end
        endfunction

        function void check_result(logic [1:0] status, logic [191:0] td);
            t_outcome e;
            if (outcome_q.size() == 0) begin
                $error("result with no item outstanding");
                fails++;
                return;
            end
            e = outcome_q.pop_front();
            compare_field("status", e.status, status);
            compare_field("popped_data", e.popped_data, td[63:0]);
            compare_field("popped_level", e.popped_level, td[66:64]);
            compare_field("next_level", e.next_level, td[70:67]);
            compare_field("total_waiting", e.total_waiting, td[78:71]);
            compare_field("level_waiting", e.level_waiting, td[84:79]);
            compare_field("queued_total", e.queued_total, td[116:85]);
            compare_field("dequeued_total", e.dequeued_total, td[148:117]);
            compare_field("overflow_total", e.overflow_total, td[180:149]);
            compare_field("peak_depth", e.peak_depth, td[186:181]);
        endfunction
    endclass

    logic          clk       = 1'b0;
    logic          rst_n     = 1'b0;
    logic          cmd_valid = 1'b0;
    logic          cmd_ready;
    logic [63:0]   cmd_data  = '0;
    logic [5:0]    cmd_user  = '0;   // command, level
    logic          res_valid;
    logic          res_ready = 1'b0;
    logic [191:0]  res_data;
    logic [1:0]    res_status;
    logic          calm      = 1'b0;

    spmf_scoreboard sb = new();

    strict_priority_multi_fifo_unit DUT (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (cmd_valid),
        .o_s_axis_tready (cmd_ready),
        .i_s_axis_tdata  (cmd_data),
        .i_s_axis_tuser  (cmd_user),
        .o_m_axis_tvalid (res_valid),
        .i_m_axis_tready (res_ready),
        .o_m_axis_tdata  (res_data),
        .o_m_axis_tuser  (res_status)
    );

    always #10 clk = ~clk;

    // mostly no gap, some short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [63:0] rand_word();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return {$urandom(), $urandom()};
    endfunction

    task automatic issue_item(logic [2:0] cmd, logic [2:0] lv, logic [63:0] data);
        int gap;
        gap = calm ? 0 : idle_len();
        if (gap > 0) begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd_user  <= {lv, cmd};
        cmd_data  <= data;
        @(posedge clk);
        while (!cmd_ready) @(posedge clk);
        sb.note_input(cmd, lv, data);
    endtask

    function automatic logic [2:0] mixed_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return CMD_PUSH;
        if (r < 80) return CMD_POP;
        if (r < 90) return CMD_READ_STATS;
        if (r < 94) return CMD_FLUSH;
        if (r < 96) return CMD_FLUSH_ALL;
        if (r < 98) return CMD_RESET_STATS;
        return (r == 98) ? CMD_SPARE_A : CMD_SPARE_B;
    endfunction

    initial begin : stimulus
        int k;
        int n;
        int lv;
        int seg;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed opening
        issue_item(CMD_POP, 3'd0, '0);              // pop with every level empty
        issue_item(CMD_RESET_STATS, 3'd0, '0);
        for (k = 0; k < 9; k++)                     // ninth push overflows the shallow level
            issue_item(CMD_PUSH, 3'd7, (k == 0) ? 64'd0 : ((k == 8) ? '1 : rand_word()));
        issue_item(CMD_PUSH, 3'd0, '1);
        issue_item(CMD_PUSH, 3'd3, rand_word());
        issue_item(CMD_POP, 3'd5, '0);
        issue_item(CMD_READ_STATS, 3'd7, '0);
        issue_item(CMD_SPARE_A, 3'd7, '1);
        issue_item(CMD_SPARE_B, 3'd0, '1);
        issue_item(CMD_FLUSH, 3'd7, '0);
        issue_item(CMD_POP, 3'd0, '0);
        issue_item(CMD_POP, 3'd0, '0);
        issue_item(CMD_PUSH, 3'd5, rand_word());
        issue_item(CMD_RESET_STATS, 3'd5, '0);     // stats cleared with a message waiting
        issue_item(CMD_READ_STATS, 3'd5, '0);
        issue_item(CMD_FLUSH_ALL, 3'd2, '0);
        issue_item(CMD_READ_STATS, 3'd0, '0);

        // random segments: fill bursts, drains, mixed traffic and single non-push commands
        while (sb.accepted < ITEM_TARGET) begin
            calm = ($urandom_range(0, 3) == 0);
            seg  = $urandom_range(0, 9);
            if (seg < 3) begin
                lv = $urandom_range(0, 7);
                n  = sb.depth_of(lv) + $urandom_range(0, 3);
                for (k = 0; k < n; k++) issue_item(CMD_PUSH, 3'(lv), rand_word());
            end else if (seg < 5) begin
                n = $urandom_range(5, 40);
                for (k = 0; k < n; k++) issue_item(CMD_POP, 3'($urandom_range(0, 7)), rand_word());
            end else if (seg < 9) begin
                for (k = 0; k < 30; k++)
                    issue_item(mixed_cmd(), 3'($urandom_range(0, 7)), rand_word());
            end else begin
                issue_item(3'($urandom_range(2, 7)), 3'($urandom_range(0, 7)), rand_word());
            end
        end
        cmd_valid <= 1'b0;

        while (sb.pending() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.fails == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // result side: random back-pressure plus one long hold-off to fill the block
    initial begin : receiver
        int n;
        bit held;
        held = 1'b0;
        wait (rst_n);
        forever begin
            if (!held && sb.accepted >= 300) begin
                held = 1'b1;
                n    = LONG_HOLD;
            end else begin
                n = idle_len();
            end
            if (n > 0) begin
                res_ready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            res_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready) sb.check_result(res_status, res_data);
    end

    initial begin : watchdog
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* strict_priority_multi_fifo_unit.f */
+incdir+sv
sv/spmf_pkg.sv
sv/spmf_store.sv
sv/spmf_queue.sv
sv/spmf_stats.sv
sv/strict_priority_multi_fifo_unit.sv
tb/sv/strict_priority_multi_fifo_unit_tb.sv
